>>> rtl/rlq_pkg.sv
// ----------------------------------------------------------------------------
// rlq_pkg
// Shared types and constants for the local run queue with run-next slot:
// opcodes, result kinds, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package rlq_pkg;

  // fixed field widths of the item and result beats
  localparam int OP_W    = 3;
  localparam int TASK_W  = 16;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUT      = 3'd0,
    OP_PUT_NEXT = 3'd1,
    OP_GET      = 3'd2,
    OP_STEAL    = 3'd3,
    OP_STATUS   = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_SPILL = 2'd2,
    KIND_STEAL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_RD,
    ST_WALK_OUT,
    ST_FINAL
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // latch the input beat
    logic exec;        // decide the step and update slot, tail and status
    logic rd_issue;    // read the ring at head and advance head
    logic load_walk;   // load the result register from ring read data
    logic load_final;  // load the result register with the closing result
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic go_walk;     // step needs ring reads (valid during exec)
    logic rem_zero;    // no ring reads left to issue
    logic fin_pend;    // a closing result follows the walk
    logic out_free;    // result register can take a beat this cycle
  } sts_t;

endpackage

>>> rtl/rlq_ctrl.sv
// ----------------------------------------------------------------------------
// rlq_ctrl
// Sequencer for the run queue: takes one item, lets the datapath decide the
// step, walks the ring one read per result if needed, then any closing beat.
// ----------------------------------------------------------------------------
module rlq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          task_valid,
  output logic          task_stall,
  input  rlq_pkg::sts_t sts,
  output rlq_pkg::cmd_t cmd
);
  import rlq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (task_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.go_walk) state_next = ST_WALK_RD;
        else if (sts.out_free) state_next = ST_IDLE;
        else state_next = ST_FINAL;
      end
      ST_WALK_RD: begin
        state_next = ST_WALK_OUT;
      end
      ST_WALK_OUT: begin
        if (sts.out_free && sts.rem_zero) begin
          state_next = sts.fin_pend ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    task_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        task_stall = 1'b0;
        cmd.accept = task_valid;
      end
      ST_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.load_final = !sts.go_walk && sts.out_free;
      end
      ST_WALK_RD: begin
        cmd.rd_issue = 1'b1;
      end
      ST_WALK_OUT: begin
        cmd.load_walk = sts.out_free;
        cmd.rd_issue  = sts.out_free && !sts.rem_zero;
      end
      ST_FINAL: begin
        cmd.load_final = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/rlq_dp.sv
// ----------------------------------------------------------------------------
// rlq_dp
// Datapath of the run queue: ring memory with head/tail pointers, run-next
// slot, step decision, walk counter and the result register.
// ----------------------------------------------------------------------------
module rlq_dp #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rlq_pkg::cmd_t                 cmd,
  output rlq_pkg::sts_t                 sts,
  input  logic [rlq_pkg::OP_W-1:0]      opcode,
  input  logic [rlq_pkg::TASK_W-1:0]    task_id,
  input  logic                          take_next,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rlq_pkg::KIND_W-1:0]    kind,
  output logic [rlq_pkg::TASK_W-1:0]    out_task,
  output logic                          keep_slice,
  output logic                          last,
  output logic                          queue_empty,
  output logic [rlq_pkg::COUNT_W-1:0]   queue_count
);
  import rlq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int SW = (ID_WIDTH < TASK_W) ? ID_WIDTH : TASK_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(QUEUE_DEPTH);

  // ring memory
  logic [SW-1:0] ring [QUEUE_DEPTH];
  logic [SW-1:0] rd_data;

  // pointers: address plus wrap bit, i.e. modulo twice the depth
  logic [AW-1:0] head_addr;
  logic          head_wrap;
  logic [AW-1:0] tail_addr;
  logic          tail_wrap;

  // run-next slot
  logic [SW-1:0] next_task;
  logic          next_valid;

  // latched input beat
  logic [OP_W-1:0] opcode_r;
  logic [SW-1:0]   task_r;
  logic            steal_r;

  // step registers
  logic [COUNT_W-1:0] walk_rem;
  kind_t              walk_kind;
  kind_t              fin_kind;
  logic [SW-1:0]      fin_task;
  logic               fin_inh;
  logic [COUNT_W-1:0] cnt_after_r;
  logic               empty_after_r;

  // step decision
  logic [COUNT_W-1:0] cnt;
  logic               full;
  logic               do_write;
  logic [SW-1:0]      wr_task;
  logic [COUNT_W-1:0] walk_n;
  kind_t              walk_kind_c;
  kind_t              fin_kind_c;
  logic [SW-1:0]      fin_task_c;
  logic               fin_inh_c;
  logic [COUNT_W-1:0] cnt_after_c;
  logic               nv_after_c;
  logic               take_slot;
  logic               out_accept;

  // entries in the ring
  always_comb begin
    if (head_wrap == tail_wrap) begin
      cnt = COUNT_W'(tail_addr) - COUNT_W'(head_addr);
    end else begin
      cnt = DEPTH_C - COUNT_W'(head_addr) + COUNT_W'(tail_addr);
    end
  end

  assign full = (cnt == DEPTH_C);

  // decide what this step does
  always_comb begin
    do_write    = 1'b0;
    wr_task     = task_r;
    walk_n      = '0;
    walk_kind_c = KIND_NONE;
    fin_kind_c  = KIND_NONE;
    fin_task_c  = '0;
    fin_inh_c   = 1'b0;
    cnt_after_c = cnt;
    nv_after_c  = next_valid;
    take_slot   = 1'b0;
    unique case (opcode_r) inside
      OP_PUT, OP_PUT_NEXT: begin
        wr_task = (opcode_r == OP_PUT_NEXT) ? next_task : task_r;
        if (opcode_r == OP_PUT_NEXT && !next_valid) begin
          nv_after_c = 1'b1;
        end else if (full) begin
          // spill the older half, then the appended task
          walk_n      = cnt >> 1;
          walk_kind_c = KIND_SPILL;
          fin_kind_c  = KIND_SPILL;
          fin_task_c  = wr_task;
          cnt_after_c = cnt - (cnt >> 1);
        end else begin
          do_write    = 1'b1;
          cnt_after_c = cnt + 1'b1;
        end
      end
      OP_GET: begin
        if (next_valid) begin
          fin_kind_c = KIND_DEQ;
          fin_task_c = next_task;
          fin_inh_c  = 1'b1;
          nv_after_c = 1'b0;
          take_slot  = 1'b1;
        end else if (cnt != '0) begin
          walk_n      = COUNT_W'(1);
          walk_kind_c = KIND_DEQ;
          cnt_after_c = cnt - 1'b1;
        end
      end
      OP_STEAL: begin
        if (cnt != '0) begin
          walk_n      = cnt - (cnt >> 1);
          walk_kind_c = KIND_STEAL;
          cnt_after_c = cnt >> 1;
        end else if (steal_r && next_valid) begin
          fin_kind_c = KIND_STEAL;
          fin_task_c = next_task;
          nv_after_c = 1'b0;
          take_slot  = 1'b1;
        end
      end
      default: begin
        walk_n = '0;
      end
    endcase
  end

  // input beat latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      opcode_r <= opcode;
      task_r   <= task_id[SW-1:0];
      steal_r  <= take_next;
    end
  end

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      ring[tail_addr] <= wr_task;
    end
    if (cmd.rd_issue) begin
      rd_data <= ring[head_addr];
    end
  end

  // pointers and run-next slot
  always_ff @(posedge clk) begin
    if (rst) begin
      head_addr  <= '0;
      head_wrap  <= 1'b0;
      tail_addr  <= '0;
      tail_wrap  <= 1'b0;
      next_task  <= '0;
      next_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (do_write) begin
          if (tail_addr == LAST_ADDR) begin
            tail_addr <= '0;
            tail_wrap <= !tail_wrap;
          end else begin
            tail_addr <= tail_addr + 1'b1;
          end
        end
        if (opcode_r == OP_PUT_NEXT) begin
          next_task <= task_r;
        end else if (take_slot) begin
          next_task <= '0;
        end
        next_valid <= nv_after_c;
      end
      if (cmd.rd_issue) begin
        if (head_addr == LAST_ADDR) begin
          head_addr <= '0;
          head_wrap <= !head_wrap;
        end else begin
          head_addr <= head_addr + 1'b1;
        end
      end
    end
  end

  // step registers for the walk and closing beat
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_rem <= '0;
    end else if (cmd.exec) begin
      walk_rem <= walk_n;
    end else if (cmd.rd_issue) begin
      walk_rem <= walk_rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      walk_kind     <= walk_kind_c;
      fin_kind      <= fin_kind_c;
      fin_task      <= fin_task_c;
      fin_inh       <= fin_inh_c;
      cnt_after_r   <= cnt_after_c;
      empty_after_r <= (cnt_after_c == '0) && !nv_after_c;
    end
  end

  // result register
  assign out_accept = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_walk || cmd.load_final) begin
      result_valid <= 1'b1;
    end else if (out_accept) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_walk) begin
      kind        <= walk_kind;
      out_task    <= TASK_W'(rd_data);
      keep_slice  <= 1'b0;
      last        <= (walk_rem == '0) && (fin_kind == KIND_NONE);
      queue_empty <= empty_after_r;
      queue_count <= cnt_after_r;
    end else if (cmd.load_final) begin
      last <= 1'b1;
      if (cmd.exec) begin
        kind        <= fin_kind_c;
        out_task    <= TASK_W'(fin_task_c);
        keep_slice  <= fin_inh_c;
        queue_empty <= (cnt_after_c == '0) && !nv_after_c;
        queue_count <= cnt_after_c;
      end else begin
        kind        <= fin_kind;
        out_task    <= TASK_W'(fin_task);
        keep_slice  <= fin_inh;
        queue_empty <= empty_after_r;
        queue_count <= cnt_after_r;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.go_walk  = (walk_n != '0);
    sts.rem_zero = (walk_rem == '0);
    sts.fin_pend = (fin_kind != KIND_NONE);
    sts.out_free = !result_valid || !result_stall;
  end

endmodule

>>> rtl/local_run_queue_with_next_slot_core.sv
// ----------------------------------------------------------------------------
// local_run_queue_with_next_slot_core
// Per-core task run queue: a ring of task ids plus a run-next slot, with put,
// put-next, get, steal-half and status; full-ring appends spill half the ring.
//
//   channel  | handshake                  | beat fields
//   ---------+----------------------------+------------------------------------
//   task     | task_valid / task_stall    | opcode, task_id, take_next
//   result   | result_valid / result_stall| kind, out_task, keep_slice, last,
//            |                            | queue_empty, queue_count
//
// An item with one result and no ring read passes idle and exec, then final
// if the result register is busy. Ring gets, ring steals and spills
// walk in walk_rd and walk_out, a spill closing with its final beat: the walk
// reads one entry per cycle through the single read port of the ring memory.
// Reset empties the ring and the run-next slot at once; no clearing pass.
// A stalled result beat holds the walk; the next item is taken as soon as
// the last result of the current one sits in the result register.
// ----------------------------------------------------------------------------
module local_run_queue_with_next_slot_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          task_valid,
  output logic                          task_stall,
  input  logic [rlq_pkg::OP_W-1:0]      opcode,
  input  logic [rlq_pkg::TASK_W-1:0]    task_id,
  input  logic                          take_next,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rlq_pkg::KIND_W-1:0]    kind,
  output logic [rlq_pkg::TASK_W-1:0]    out_task,
  output logic                          keep_slice,
  output logic                          last,
  output logic                          queue_empty,
  output logic [rlq_pkg::COUNT_W-1:0]   queue_count
);
  import rlq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rlq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_stall (task_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // ring, slot and result register
  rlq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .task_id      (task_id),
    .take_next    (take_next),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_task     (out_task),
    .keep_slice   (keep_slice),
    .last         (last),
    .queue_empty  (queue_empty),
    .queue_count  (queue_count)
  );

  // ring never reports more entries than it holds
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (queue_count <= COUNT_W'(QUEUE_DEPTH)))
    else $error("queue_count beyond ring depth");

  // an empty beat carries no task
  a_none_no_task: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_NONE) |-> (out_task == '0 && !keep_slice))
    else $error("kind none with task payload");

  // time slice is kept only by a get from the run-next slot, which ends the item
  a_inherit_deq: assert property (@(posedge clk) disable iff (rst)
    (result_valid && keep_slice) |-> (kind == KIND_DEQ && last))
    else $error("keep_slice on a non-dequeue beat");

  // no new item is taken while a walk or closing beat is still owed
  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> task_stall)
    else $error("item accepted before previous item finished");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-core run queue with run-next slot. A table
// of directed beats covers the corners, then traffic bursts that fill the
// ring into spills and drain it by gets and steals, under four idling
// profiles. A model in the bench predicts each beat the table does not list.
// ----------------------------------------------------------------------------
module testbench;
  import rlq_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int ITEMS_PER_PHASE = 89;
  localparam int MAX_REPORTS = 30;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_STATUS + 1);
  localparam logic [OP_W-1:0] OP_SPARE_LAST = OP_W'((1 << OP_W) - 1);

  typedef struct packed {
    kind_t               kind;
    logic [TASK_W-1:0]   tid;
    logic                inherit;
    logic                last;
    logic                empty;
    logic [COUNT_W-1:0]  count;
  } result_beat_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TASK_W-1:0]   tid;
    logic                take_next;
    logic                typed;
    result_beat_t        beat;
  } stim_row_t;

  typedef enum logic [1:0] {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                task_valid = 1'b0;
  logic                task_stall;
  logic [OP_W-1:0]     opcode = OP_STATUS;
  logic [TASK_W-1:0]   task_id = '0;
  logic                take_next = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [TASK_W-1:0]   out_task;
  logic                keep_slice;
  logic                last;
  logic                queue_empty;
  logic [COUNT_W-1:0]  queue_count;

  // queue model state
  logic [TASK_W-1:0]   ring_mem [RING_DEPTH];
  logic [COUNT_W-1:0]  head_ptr = '0;
  logic [COUNT_W-1:0]  tail_ptr = '0;
  logic [TASK_W-1:0]   slot_task = '0;
  logic                slot_full = 1'b0;

  result_beat_t        step_beats [$];
  result_beat_t        pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int spill_beats = 0;
  int stolen_beats = 0;
  int slot_gets = 0;

  always #5 clk = ~clk;

  local_run_queue_with_next_slot_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (task_valid),
    .task_stall   (task_stall),
    .opcode       (opcode),
    .task_id      (task_id),
    .take_next    (take_next),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_task     (out_task),
    .keep_slice   (keep_slice),
    .last         (last),
    .queue_empty  (queue_empty),
    .queue_count  (queue_count)
  );

  // ---------------------------------------------------------------- model

  task automatic emit_beat(input kind_t k, input logic [TASK_W-1:0] t, input logic inh);
    result_beat_t b;
    b = '0;
    b.kind = k;
    b.tid = t;
    b.inherit = inh;
    step_beats.push_back(b);
  endtask

  task automatic ring_pop(output logic [TASK_W-1:0] v);
    v = ring_mem[head_ptr % RING_DEPTH];
    head_ptr = head_ptr + 1'b1;
  endtask

  // append at the tail, or spill the older half plus the new task when full
  task automatic ring_append(input logic [TASK_W-1:0] v);
    logic [COUNT_W-1:0] fill;
    logic [TASK_W-1:0]  old;
    int i;
    fill = tail_ptr - head_ptr;
    if (fill < RING_DEPTH) begin
      ring_mem[tail_ptr % RING_DEPTH] = v;
      tail_ptr = tail_ptr + 1'b1;
      emit_beat(KIND_NONE, '0, 1'b0);
    end else begin
      for (i = 0; i < fill / 2; i++) begin
        ring_pop(old);
        emit_beat(KIND_SPILL, old, 1'b0);
      end
      emit_beat(KIND_SPILL, v, 1'b0);
    end
  endtask

  // one queue operation; leaves its result beats in step_beats
  task automatic run_queue_step(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] tid,
                                input logic sn);
    logic [TASK_W-1:0]  v;
    logic [COUNT_W-1:0] fill;
    int n;
    int i;
    step_beats.delete();
    fill = tail_ptr - head_ptr;
    case (op)
      OP_PUT: begin
        ring_append(tid);
      end
      OP_PUT_NEXT: begin
        if (slot_full) begin
          v = slot_task;
          slot_task = tid;
          ring_append(v);
        end else begin
          slot_task = tid;
          slot_full = 1'b1;
          emit_beat(KIND_NONE, '0, 1'b0);
        end
      end
      OP_GET: begin
        if (slot_full) begin
          emit_beat(KIND_DEQ, slot_task, 1'b1);
          slot_full = 1'b0;
          slot_task = '0;
        end else if (fill != 0) begin
          ring_pop(v);
          emit_beat(KIND_DEQ, v, 1'b0);
        end else begin
          emit_beat(KIND_NONE, '0, 1'b0);
        end
      end
      OP_STEAL: begin
        if (fill != 0) begin
          n = fill - fill / 2;
          for (i = 0; i < n; i++) begin
            ring_pop(v);
            emit_beat(KIND_STEAL, v, 1'b0);
          end
        end else if (sn && slot_full) begin
          emit_beat(KIND_STEAL, slot_task, 1'b0);
          slot_full = 1'b0;
          slot_task = '0;
        end else begin
          emit_beat(KIND_NONE, '0, 1'b0);
        end
      end
      default: begin
        emit_beat(KIND_NONE, '0, 1'b0);
      end
    endcase
    // status fields carry the after-step values on every beat
    fill = tail_ptr - head_ptr;
    for (i = 0; i < step_beats.size(); i++) begin
      step_beats[i].last = (i == step_beats.size() - 1);
      step_beats[i].empty = (fill == 0) && !slot_full;
      step_beats[i].count = fill;
    end
  endtask

  // ---------------------------------------------------------------- driver

  // present one item, hold it until taken, then queue its expected beats
  task automatic drive_item(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] tid,
                            input logic sn, input logic typed, input result_beat_t typed_beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      task_valid <= 1'b0;
      @(posedge clk);
    end
    task_valid <= 1'b1;
    opcode <= op;
    task_id <= tid;
    take_next <= sn;
    @(posedge clk);
    while (task_stall) @(posedge clk);
    items_sent++;
    run_queue_step(op, tid, sn);
    if (typed) begin
      pending_results.push_back(typed_beat);
    end else begin
      foreach (step_beats[i]) pending_results.push_back(step_beats[i]);
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string what);
    error_count++;
    // keep the log short when a broken block floods it
    if (error_count <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_result_beat();
    result_beat_t got;
    result_beat_t want;
    got = '{kind_t'(kind), out_task, keep_slice, last, queue_empty, queue_count};
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("beat with nothing pending: kind=%0d task=%h", got.kind,
                                got.tid));
    end else begin
      want = pending_results.pop_front();
      beats_checked++;
      if (got !== want) begin
        report_mismatch($sformatf(
          "got kind=%0d task=%h inh=%b last=%b empty=%b cnt=%0d, want %0d %h %b %b %b %0d",
          got.kind, got.tid, got.inherit, got.last, got.empty, got.count,
          want.kind, want.tid, want.inherit, want.last, want.empty, want.count));
      end
      case (want.kind)
        KIND_SPILL: spill_beats++;
        KIND_STEAL: stolen_beats++;
        KIND_DEQ:   if (want.inherit) slot_gets++;
        default: ;
      endcase
    end
  endtask

  // result side: random stall, check each beat taken
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst && result_valid && !result_stall) check_result_beat();
  end

  // ---------------------------------------------------------------- stimulus

  stim_row_t directed_rows [23];

  initial begin
    int phase;
    int k;
    int roll;
    int burst_left;
    traffic_t traffic;
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] tid;
    logic              sn;

    directed_rows = '{
      // empty queue: status, get and steal find nothing
      '{OP_STATUS,      16'h5a5a, 1'b1, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b1, 7'd0}},
      '{OP_GET,         16'h0000, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b1, 7'd0}},
      '{OP_STEAL,       16'h0000, 1'b1, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b1, 7'd0}},
      // id extremes into the ring, then fill and displace the run-next slot
      '{OP_PUT,         16'hffff, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd1}},
      '{OP_PUT,         16'h0000, 1'b1, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd2}},
      '{OP_PUT_NEXT,    16'h1234, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd2}},
      '{OP_PUT_NEXT,    16'habcd, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd3}},
      // run-next served first, then the ring head
      '{OP_GET,         16'h0000, 1'b0, 1'b1, '{KIND_DEQ, 16'habcd, 1'b1, 1'b1, 1'b0, 7'd3}},
      '{OP_GET,         16'h0000, 1'b0, 1'b1, '{KIND_DEQ, 16'hffff, 1'b0, 1'b1, 1'b0, 7'd2}},
      '{OP_STEAL,       16'h0000, 1'b0, 1'b1, '{KIND_STEAL, 16'h0000, 1'b0, 1'b1, 1'b0, 7'd1}},
      // multi-beat steal
      '{OP_PUT,         16'h8001, 1'b0, 1'b0, '0},
      '{OP_PUT,         16'h7ffe, 1'b1, 1'b0, '0},
      '{OP_STEAL,       16'h0000, 1'b0, 1'b0, '0},
      // undefined opcodes behave as status
      '{OP_SPARE_FIRST, 16'hffff, 1'b1, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd1}},
      '{OP_SPARE_FIRST + 1'b1, 16'h0000, 1'b0, 1'b1,
        '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd1}},
      '{OP_SPARE_LAST,  16'hffff, 1'b1, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd1}},
      '{OP_GET,         16'h0000, 1'b0, 1'b1, '{KIND_DEQ, 16'h7ffe, 1'b0, 1'b1, 1'b1, 7'd0}},
      // empty ring: steal keeps the slot unless take_next is set
      '{OP_PUT_NEXT,    16'h0f0f, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd0}},
      '{OP_STEAL,       16'h0000, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd0}},
      '{OP_STEAL,       16'h0000, 1'b1, 1'b1, '{KIND_STEAL, 16'h0f0f, 1'b0, 1'b1, 1'b1, 7'd0}},
      '{OP_PUT_NEXT,    16'hf0f0, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b0, 7'd0}},
      '{OP_GET,         16'h0000, 1'b1, 1'b1, '{KIND_DEQ, 16'hf0f0, 1'b1, 1'b1, 1'b1, 7'd0}},
      '{OP_GET,         16'h0000, 1'b0, 1'b1, '{KIND_NONE, 16'h0, 1'b0, 1'b1, 1'b1, 7'd0}}
    };

    // reset
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, no idling
    foreach (directed_rows[r])
      drive_item(directed_rows[r].op, directed_rows[r].tid, directed_rows[r].take_next,
                 directed_rows[r].typed, directed_rows[r].beat);

    // random bursts; the first one fills the ring past full to force spills
    traffic = TRAFFIC_FILL;
    burst_left = 70 + $urandom_range(0, 10);
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) begin
            traffic = TRAFFIC_FILL;
            burst_left = $urandom_range(40, 80);
          end else if (roll < 80) begin
            traffic = TRAFFIC_DRAIN;
            burst_left = $urandom_range(10, 40);
          end else begin
            traffic = TRAFFIC_MIXED;
            burst_left = $urandom_range(10, 30);
          end
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        case (traffic)
          TRAFFIC_FILL:
            op = (roll < 60) ? OP_PUT : (roll < 85) ? OP_PUT_NEXT :
                 (roll < 92) ? OP_GET : (roll < 97) ? OP_STEAL : OP_STATUS;
          TRAFFIC_DRAIN:
            op = (roll < 40) ? OP_GET : (roll < 75) ? OP_STEAL :
                 (roll < 88) ? OP_PUT : (roll < 93) ? OP_PUT_NEXT : OP_STATUS;
          default:
            op = (roll < 25) ? OP_PUT : (roll < 45) ? OP_PUT_NEXT :
                 (roll < 65) ? OP_GET : (roll < 85) ? OP_STEAL : OP_STATUS;
        endcase
        // status slots sometimes carry an undefined opcode
        if (op == OP_STATUS && $urandom_range(0, 1))
          op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        tid = TASK_W'($urandom_range(0, (1 << TASK_W) - 1));
        sn = 1'($urandom_range(0, 1));
        drive_item(op, tid, sn, 1'b0, '0);
      end
    end
    task_valid <= 1'b0;

    // drain, then give stray beats a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("summary: %0d items, %0d result beats checked, %0d errors", items_sent,
             beats_checked, error_count);
    $display("summary: %0d spill beats, %0d stolen beats, %0d run-next gets", spill_beats,
             stolen_beats, slot_gets);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
